// ===== hdl/ctd_pkg.sv =====
// Package for the coefficient template context block: sizes, codes, payload types and offsets.
`default_nettype none
package ctd_pkg;

	localparam int MAX_SIDE = 64;
	localparam int SIDE_W = $clog2(MAX_SIDE);
	localparam int ADDR_W = 2 * SIDE_W;
	localparam int DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int COEFF_W = 16;
	localparam int NB_COUNT = 5;
	localparam int IDX_W = 3;
	localparam int MAG_W = COEFF_W + 1;
	localparam int ABS_W = MAG_W + 1;
	localparam logic [6:0] SIDE_LIMIT = 7'(MAX_SIDE);

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;
	localparam logic COMP_LUMA = 1'b0;

	typedef struct packed {
		logic               req_type;
		logic [5:0]         pos_x;
		logic [5:0]         pos_y;
		logic signed [15:0] coeff_value;
		logic [6:0]         block_width;
		logic [6:0]         block_height;
		logic               component;
		logic [2:0]         base_level;
	} ctd_req_t;

	typedef struct packed {
		logic [4:0] sig_ctx;
		logic [6:0] diag_sum;
		logic [4:0] partial_sum;
		logic [4:0] rice_slot;
	} ctd_res_t;

	typedef struct packed {
		logic clear;
		logic en;
	} ctd_acc_ctl_t;

	typedef struct packed {
		logic [4:0]       sum_clip;
		logic [4:0]       part;
		logic [ABS_W-1:0] sum_abs;
	} ctd_acc_sum_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_QUERY,
		ST_FIN
	} ctd_state_t;

	// Template order: right, right+2, below-right, below, below+2.
	function automatic logic [1:0] nb_dx(input logic [IDX_W-1:0] idx);
		logic [1:0] d;
		case (idx)
			3'd0: d = 2'd1;
			3'd1: d = 2'd2;
			3'd2: d = 2'd1;
			default: d = 2'd0;
		endcase
		return d;
	endfunction

	function automatic logic [1:0] nb_dy(input logic [IDX_W-1:0] idx);
		logic [1:0] d;
		case (idx)
			3'd2: d = 2'd1;
			3'd3: d = 2'd1;
			3'd4: d = 2'd2;
			default: d = 2'd0;
		endcase
		return d;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/ctd_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none
module ctd_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule
`default_nettype wire

// ===== hdl/ctd_acc.sv =====
// Shared neighbour unit: magnitude, clipping and the three running sums.
`default_nettype none
module ctd_acc
	import ctd_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire ctd_acc_ctl_t        ctl,
	input  wire logic [COEFF_W-1:0]  rdata,
	output ctd_acc_sum_t             sums
);

	logic signed [MAG_W-1:0] val;
	logic [MAG_W-1:0]        mag;
	logic [2:0]              lim;
	logic [2:0]              clip;
	logic                    nz;
	ctd_acc_sum_t            sums_q;

	always_comb begin
		val  = MAG_W'($signed(rdata));
		mag  = val[MAG_W-1] ? MAG_W'(-val) : MAG_W'(val);
		lim  = 3'd4 + {2'b00, mag[0]};
		clip = (mag < MAG_W'(lim)) ? mag[2:0] : lim;
		nz   = (mag != '0);
	end

	// Clipped value minus the nonzero flag never goes negative, so the partial
	// sum is kept directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sums_q <= '0;
		end else if (ctl.clear) begin
			sums_q <= '0;
		end else if (ctl.en) begin
			sums_q.sum_clip <= sums_q.sum_clip + 5'(clip);
			sums_q.part     <= sums_q.part + 5'(clip) - 5'(nz);
			sums_q.sum_abs  <= sums_q.sum_abs + ABS_W'(mag);
		end
	end

	assign sums = sums_q;

endmodule
`default_nettype wire

// ===== hdl/coeff_template_context_derive.sv =====
// Top level: coefficient store, neighbour sequencer and result formation.
// A write item is taken as soon as it is accepted and busy stays low, so writes may follow every cycle.
// A query item keeps busy high through ST_QUERY, with five neighbour reads through the single
// memory port and a drain of the registered read, and then through ST_FIN, which forms the result.
// done pulses for one cycle in the first cycle that busy is low; a new item may be started then.
// Reset clears the sequencer and the strobe; the coefficient store is not cleared.
`default_nettype none
module coeff_template_context_derive
	import ctd_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire ctd_req_t req,
	output logic          busy,
	output logic          done,
	output ctd_res_t      res
);

	ctd_state_t       state_q, state_d;
	logic [IDX_W-1:0] idx_q;
	logic             pend_q;
	logic [5:0]       x_q, y_q;
	logic [6:0]       w_q, h_q;
	logic             chroma_q;
	logic [2:0]       base_q;
	logic             done_q;
	ctd_res_t         res_q;

	logic             accept;
	logic             wr_en;
	logic [6:0]       nx, ny;
	logic             present;
	logic [ADDR_W-1:0] ram_addr;
	logic [COEFF_W-1:0] ram_rdata;
	ctd_acc_ctl_t     acc_ctl;
	ctd_acc_sum_t     acc_sums;

	logic [6:0]       diag;
	logic [4:0]       ctx_clip;
	logic [4:0]       ctx;
	logic [5:0]       base5;
	logic [ABS_W-1:0] slot_diff;
	logic [4:0]       slot;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign wr_en  = accept && (req.req_type == REQ_WRITE)
		&& ({1'b0, req.pos_x} < SIDE_LIMIT) && ({1'b0, req.pos_y} < SIDE_LIMIT);

	always_comb begin
		nx = 7'(x_q) + 7'(nb_dx(idx_q));
		ny = 7'(y_q) + 7'(nb_dy(idx_q));
		present = (idx_q < IDX_W'(NB_COUNT)) && (nx < w_q) && (ny < h_q);
		if (wr_en) begin
			ram_addr = {req.pos_y[SIDE_W-1:0], req.pos_x[SIDE_W-1:0]};
		end else begin
			ram_addr = {ny[SIDE_W-1:0], nx[SIDE_W-1:0]};
		end
	end

	ctd_ram #(
		.WIDTH(COEFF_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.addr  (ram_addr),
		.wdata (req.coeff_value),
		.rdata (ram_rdata)
	);

	ctd_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (acc_ctl),
		.rdata  (ram_rdata),
		.sums   (acc_sums)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Each query cycle adds the neighbour read in the cycle before and issues the next read.
	always_comb begin
		state_d     = state_q;
		acc_ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept && (req.req_type == REQ_QUERY)) begin
					state_d       = ST_QUERY;
					acc_ctl.clear = 1'b1;
				end
			end
			ST_QUERY: begin
				acc_ctl.en = pend_q;
				if (idx_q == IDX_W'(NB_COUNT)) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			pend_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			idx_q  <= (state_q == ST_QUERY) ? idx_q + 1'b1 : '0;
			pend_q <= (state_q == ST_QUERY) && present;
			done_q <= (state_q == ST_FIN);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req.req_type == REQ_QUERY)) begin
			x_q      <= req.pos_x;
			y_q      <= req.pos_y;
			w_q      <= (req.block_width > SIDE_LIMIT) ? SIDE_LIMIT : req.block_width;
			h_q      <= (req.block_height > SIDE_LIMIT) ? SIDE_LIMIT : req.block_height;
			chroma_q <= req.component;
			base_q   <= req.base_level;
		end
		if (state_q == ST_FIN) begin
			res_q.sig_ctx     <= ctx;
			res_q.diag_sum    <= diag;
			res_q.partial_sum <= acc_sums.part;
			res_q.rice_slot   <= slot;
		end
	end

	always_comb begin
		diag     = 7'(x_q) + 7'(y_q);
		ctx_clip = (acc_sums.sum_clip > 5'd5) ? 5'd5 : acc_sums.sum_clip;
		ctx      = ctx_clip + ((diag < 7'd2) ? 5'd6 : 5'd0)
			+ (((chroma_q == COMP_LUMA) && (diag < 7'd5)) ? 5'd6 : 5'd0);
		base5     = {1'b0, base_q, 2'b00} + 6'(base_q);
		slot_diff = acc_sums.sum_abs - ABS_W'(base5);
		if (acc_sums.sum_abs <= ABS_W'(base5)) begin
			slot = 5'd0;
		end else if (slot_diff > ABS_W'(31)) begin
			slot = 5'd31;
		end else begin
			slot = slot_diff[4:0];
		end
	end

	assign done = done_q;
	assign res  = res_q;

`ifndef SYNTHESIS
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while a query is in progress");
	a_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_IDLE))
		else $error("store written during a query");
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.req_type == REQ_QUERY)) |=> busy)
		else $error("query accepted without raising busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");
	a_no_read_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> !pend_q)
		else $error("neighbour read still pending when forming the result");
`endif

endmodule
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for the coefficient template context block: writes and queries, all results checked.
`timescale 1ns / 1ps
module tb;
	import ctd_pkg::*;

	localparam int CLK_PERIOD = 8;
	localparam int ITEM_TARGET = 840;
	localparam int STALL_LIMIT = 1000;
	localparam int DRAIN_CYCLES = 16;

	// Keeps a copy of the coefficient store and the context values still owed by the block.
	class template_ledger;
		logic signed [COEFF_W-1:0] level_mem [DEPTH];
		ctd_res_t expected_ctx [$];
		int col_step [5] = '{1, 2, 1, 0, 0};
		int row_step [5] = '{0, 0, 1, 1, 2};
		int n_writes;
		int n_queries;
		int n_compared;
		int fail_count;

		function ctd_res_t derive_context(ctd_req_t r);
			ctd_res_t o;
			int w, h, k, nx, ny, a, lim, clip_sum, nonzero, abs_sum, diag, ctx, slot;
			w = (r.block_width > SIDE_LIMIT) ? MAX_SIDE : int'(r.block_width);
			h = (r.block_height > SIDE_LIMIT) ? MAX_SIDE : int'(r.block_height);
			clip_sum = 0;
			nonzero = 0;
			abs_sum = 0;
			for (k = 0; k < NB_COUNT; k++) begin
				nx = int'(r.pos_x) + col_step[k];
				ny = int'(r.pos_y) + row_step[k];
				if (nx < w && ny < h) begin
					a = level_mem[ny * MAX_SIDE + nx];
					if (a < 0)
						a = -a;
					// Odd magnitudes are allowed one step more before clipping.
					lim = 4 + (a & 1);
					clip_sum += (a < lim) ? a : lim;
					if (a != 0)
						nonzero++;
					abs_sum += a;
				end
			end
			diag = int'(r.pos_x) + int'(r.pos_y);
			ctx = ((clip_sum < 5) ? clip_sum : 5) + ((diag < 2) ? 6 : 0);
			if (r.component == COMP_LUMA && diag < 5)
				ctx += 6;
			slot = abs_sum - 5 * int'(r.base_level);
			if (slot > 31)
				slot = 31;
			if (slot < 0)
				slot = 0;
			o.sig_ctx = 5'(ctx);
			o.diag_sum = 7'(diag);
			o.partial_sum = 5'(clip_sum - nonzero);
			o.rice_slot = 5'(slot);
			return o;
		endfunction

		function void note_item(ctd_req_t r);
			if (r.req_type == REQ_WRITE) begin
				if (int'(r.pos_x) < MAX_SIDE && int'(r.pos_y) < MAX_SIDE)
					level_mem[int'(r.pos_y) * MAX_SIDE + int'(r.pos_x)] = r.coeff_value;
				n_writes++;
			end else begin
				expected_ctx.push_back(derive_context(r));
				n_queries++;
			end
		endfunction

		function void check_result(ctd_res_t got);
			ctd_res_t exp_ctx;
			if (expected_ctx.size() == 0) begin
				$error("result strobe with no query outstanding: %h", got);
				fail_count++;
				return;
			end
			exp_ctx = expected_ctx.pop_front();
			n_compared++;
			if (got.sig_ctx !== exp_ctx.sig_ctx) begin
				$error("sig_ctx: expected %0d, got %0d", exp_ctx.sig_ctx, got.sig_ctx);
				fail_count++;
			end
			if (got.diag_sum !== exp_ctx.diag_sum) begin
				$error("diag_sum: expected %0d, got %0d", exp_ctx.diag_sum, got.diag_sum);
				fail_count++;
			end
			if (got.partial_sum !== exp_ctx.partial_sum) begin
				$error("partial_sum: expected %0d, got %0d", exp_ctx.partial_sum,
					got.partial_sum);
				fail_count++;
			end
			if (got.rice_slot !== exp_ctx.rice_slot) begin
				$error("rice_slot: expected %0d, got %0d", exp_ctx.rice_slot, got.rice_slot);
				fail_count++;
			end
		endfunction

		function int waiting();
			return expected_ctx.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	ctd_req_t req = '0;
	logic busy;
	logic done;
	ctd_res_t res;

	template_ledger ledger = new();
	bit written [DEPTH];
	int n_items = 0;
	int quiet_cycles = 0;

	coeff_template_context_derive dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.req(req),
		.busy(busy),
		.done(done),
		.res(res)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				ledger.check_result(res);
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("coeff_template_context_derive regression: fail");
					$finish;
				end
			end
		end
	end

	function automatic logic signed [15:0] level_pick();
		int mag;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: mag = 0;
			4, 5, 6: mag = $urandom_range(1, 6);
			7: mag = $urandom_range(7, 400);
			8: return 16'($urandom);
			default: return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
		endcase
		return ($urandom_range(0, 1) != 0) ? 16'(-mag) : 16'(mag);
	endfunction

	// Presents one item and returns at the edge that accepts it.
	task automatic drive_item(input ctd_req_t r);
		int idle_pct;
		case ((n_items / 120) % 3)
			0: idle_pct = 0;
			1: idle_pct = 60;
			default: idle_pct = 6;
		endcase
		while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		do
			@(posedge clk);
		while (busy);
		ledger.note_item(r);
		n_items++;
	endtask

	task automatic write_coeff(input int x, input int y, input logic signed [15:0] level);
		ctd_req_t r;
		r.req_type = REQ_WRITE;
		r.pos_x = 6'(x);
		r.pos_y = 6'(y);
		r.coeff_value = level;
		r.block_width = 7'($urandom);
		r.block_height = 7'($urandom);
		r.component = 1'($urandom);
		r.base_level = 3'($urandom);
		written[y * MAX_SIDE + x] = 1'b1;
		drive_item(r);
	endtask

	// Any neighbour that the query can see and that was never written is written first.
	task automatic query_at(input int x, input int y, input int w, input int h,
		input logic comp, input int base);
		ctd_req_t r;
		int cw, ch, nx, ny;
		cw = (w > MAX_SIDE) ? MAX_SIDE : w;
		ch = (h > MAX_SIDE) ? MAX_SIDE : h;
		for (ny = y; ny <= y + 2; ny++)
			for (nx = x; nx <= x + 2; nx++)
				if (nx < cw && ny < ch && !written[ny * MAX_SIDE + nx])
					write_coeff(nx, ny, level_pick());
		r.req_type = REQ_QUERY;
		r.pos_x = 6'(x);
		r.pos_y = 6'(y);
		r.coeff_value = 16'($urandom);
		r.block_width = 7'(w);
		r.block_height = 7'(h);
		r.component = comp;
		r.base_level = 3'(base);
		drive_item(r);
	endtask

	initial begin
		int bw, bh, pick, nq, x, y;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes of the level range around the origin, then the edge and size cases.
		write_coeff(0, 0, 16'sd0);
		write_coeff(1, 0, 16'sh7fff);
		write_coeff(2, 0, 16'sh8000);
		write_coeff(1, 1, -16'sd1);
		write_coeff(0, 1, 16'sd5);
		write_coeff(0, 2, 16'sd4);
		query_at(0, 0, 3, 3, COMP_LUMA, 0);
		query_at(0, 0, 0, 0, ~COMP_LUMA, 7);
		query_at(0, 0, 127, 127, COMP_LUMA, 7);
		query_at(0, 0, 1, 2, COMP_LUMA, 3);
		query_at(0, 0, 64, 0, ~COMP_LUMA, 0);
		query_at(63, 63, 64, 64, ~COMP_LUMA, 0);
		query_at(62, 62, 64, 64, COMP_LUMA, 1);
		query_at(10, 10, 4, 4, COMP_LUMA, 0);
		query_at(1, 1, 3, 3, COMP_LUMA, 2);

		// Mostly a small block filled and then queried, with some stray writes and
		// queries of any size anywhere.
		while (n_items < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 75) begin
				bw = $urandom_range(1, 6);
				bh = $urandom_range(1, 6);
			end else if (pick < 90) begin
				bw = $urandom_range(1, 32);
				bh = $urandom_range(1, 2);
			end else begin
				bw = $urandom_range(1, 2);
				bh = $urandom_range(1, 32);
			end
			for (y = 0; y < bh; y++)
				for (x = 0; x < bw; x++)
					write_coeff(x, y, level_pick());
			nq = $urandom_range(3, 12);
			repeat (nq) begin
				pick = $urandom_range(0, 99);
				if (pick < 80)
					query_at($urandom_range(0, bw - 1), $urandom_range(0, bh - 1), bw, bh,
						1'($urandom), $urandom_range(0, 7));
				else if (pick < 92)
					query_at($urandom_range(0, 63), $urandom_range(0, 63),
						$urandom_range(0, 127), $urandom_range(0, 127),
						1'($urandom), $urandom_range(0, 7));
				else
					write_coeff($urandom_range(0, 63), $urandom_range(0, 63), level_pick());
			end
		end
		start <= 1'b0;

		while (ledger.waiting() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d items: %0d coefficient writes and %0d template queries.",
			n_items, ledger.n_writes, ledger.n_queries);
		$display("%0d context results compared, %0d field mismatches or stray strobes.",
			ledger.n_compared, ledger.fail_count);
		if (ledger.fail_count == 0)
			$display("coeff_template_context_derive regression: pass");
		else
			$display("coeff_template_context_derive regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/ctd_pkg.sv
hdl/ctd_ram.sv
hdl/ctd_acc.sv
hdl/coeff_template_context_derive.sv
sim/tb.sv
